// ===== rtl/sscc_pkg.sv =====
// shared types and constants of the servo speed command control block
package sscc_pkg;

   localparam int PW_BITS   = 12;
   localparam int GAIN_BITS = 4;
   localparam int CMD_BITS  = 8;
   localparam int REQ_TDATA_BITS = 16;
   localparam int RSP_TDATA_BITS = 40;
   localparam int CSR_IDX_BITS   = 2;
   localparam int FRAME_BITS     = 3;

   localparam logic [PW_BITS-1:0]   RESET_STOP = 12'd1426;
   localparam logic [GAIN_BITS-1:0] RESET_GAIN = 4'd3;
   localparam logic [PW_BITS-1:0]   RESET_MIN  = 12'd500;
   localparam logic [PW_BITS-1:0]   RESET_MAX  = 12'd2400;

   localparam logic [CSR_IDX_BITS-1:0] CSR_STOP_WIDTH = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_GAIN  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_WIDTH  = 2'd3;

   localparam logic [CMD_BITS-1:0] CMD_NONE   = 8'h00;
   localparam logic [CMD_BITS-1:0] CMD_PLUS   = 8'h2B;
   localparam logic [CMD_BITS-1:0] CMD_LOWL   = 8'h6C;
   localparam logic [CMD_BITS-1:0] CMD_MINUS  = 8'h2D;
   localparam logic [CMD_BITS-1:0] CMD_LOWR   = 8'h72;
   localparam logic [CMD_BITS-1:0] CMD_SPACE  = 8'h20;

   typedef struct packed {
      logic load;
      logic square;
      logic scale;
      logic clamp;
      logic emit;
   } sscc_cmd_type;

endpackage

// ===== rtl/sscc_ctrl.sv =====
// sequencer for one control tick: accept, square, scale, clamp, hand off result
module sscc_ctrl
   import sscc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output sscc_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_SCALE,
      S_CLAMP,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd        = '0;
      cmd.load   = (state_ff == S_IDLE) && req_tvalid;
      cmd.square = (state_ff == S_SQUARE);
      cmd.scale  = (state_ff == S_SCALE);
      cmd.clamp  = (state_ff == S_CLAMP);
      cmd.emit   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) state_ff <= S_SQUARE;
            end
            S_SQUARE: state_ff <= S_SCALE;
            S_SCALE:  state_ff <= S_CLAMP;
            S_CLAMP:  state_ff <= S_DONE;
            S_DONE: begin
               if (!rsp_valid_ff || rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken while a transaction is in work");

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten before handoff");

   a_emit_shows_result: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_tvalid)
      else $error("result not presented after emit");

endmodule

// ===== rtl/sscc_datapath.sv =====
// control state, speed curve arithmetic, clamp and result register
module sscc_datapath
   import sscc_pkg::*;
#(
   parameter int STEP_LIMIT = 63
)(
   input  logic                      clock,
   input  logic                      reset,
   input  sscc_cmd_type              cmd,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [PW_BITS-1:0]        csr_wdata
);

   localparam int SW = $clog2(STEP_LIMIT + 1) + 1;
   localparam int MW = $clog2(STEP_LIMIT + 2);
   localparam int QW = 2 * MW;
   localparam int PRW = QW + GAIN_BITS;
   localparam int VW = ((PRW > PW_BITS) ? PRW : PW_BITS) + 2;
   localparam logic signed [SW-1:0] LIM_POS = SW'(STEP_LIMIT);
   localparam logic signed [SW-1:0] LIM_NEG = -SW'(STEP_LIMIT);

   logic [PW_BITS-1:0]   stop_ff, min_ff, max_ff;
   logic [GAIN_BITS-1:0] gain_ff;

   logic signed [SW-1:0]  step_ff, step_in;
   logic [PW_BITS-1:0]    pulse_ff;
   logic                  pause_ff, pause_in;
   logic                  lock_ff, lock_in;
   logic [FRAME_BITS-1:0] frame_ff;
   logic                  upd_ff;
   logic                  up_ff, down_ff, go_ff, hold_ff, reject_ff, report_ff, blink_ff;
   logic [QW-1:0]         sq_ff;
   logic [PRW-1:0]        prod_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_ff;

   logic                right, stop, left;
   logic [CMD_BITS-1:0] cmd_byte;
   logic                cmd_nz, up_req, down_req, tog_req;
   logic                up_act, down_act, tog_act;
   logic signed [SW-1:0] s_up, s_dn;
   logic                p_up, p_dn, go_act, hold_act;

   logic signed [SW-1:0] step_neg, step_mag;
   logic [MW-1:0]        mp1;
   logic signed [VW-1:0] stop_x, prod_x, min_x, max_x, v_raw, v_lo, v_clamp;
   logic [PW_BITS-1:0]   drive;

   assign right    = req_tdata[0];
   assign stop     = req_tdata[1];
   assign left     = req_tdata[2];
   assign cmd_byte = req_tdata[3 +: CMD_BITS];

   always_comb begin
      cmd_nz   = (cmd_byte != CMD_NONE);
      up_req   = right || (cmd_byte == CMD_PLUS) || (cmd_byte == CMD_LOWL);
      down_req = left || (cmd_byte == CMD_MINUS) || (cmd_byte == CMD_LOWR);
      tog_req  = stop || (cmd_byte == CMD_SPACE);
      up_act   = !lock_ff && up_req;
      down_act = !lock_ff && down_req;
      tog_act  = !lock_ff && tog_req;

      if (lock_ff) begin
         lock_in = right || stop || left;
      end else begin
         lock_in = (up_req || down_req || tog_req) && !cmd_nz;
      end

      s_up = step_ff;
      p_up = pause_ff;
      if (up_act) begin
         if (pause_ff) s_up = '0;
         if (s_up < LIM_POS) s_up = s_up + SW'(1);
         p_up = 1'b0;
      end
      s_dn = s_up;
      p_dn = p_up;
      if (down_act) begin
         if (p_up) s_dn = '0;
         if (s_dn > LIM_NEG) s_dn = s_dn - SW'(1);
         p_dn = 1'b0;
      end
      step_in  = s_dn;
      go_act   = tog_act && p_dn;
      hold_act = tog_act && !p_dn;
      pause_in = tog_act ? !p_dn : p_dn;
   end

   always_comb begin
      step_neg = -step_ff;
      step_mag = step_ff[SW-1] ? step_neg : step_ff;
      mp1      = step_mag[MW-1:0] + MW'(1);
      stop_x   = $signed({{(VW-PW_BITS){1'b0}}, stop_ff});
      min_x    = $signed({{(VW-PW_BITS){1'b0}}, min_ff});
      max_x    = $signed({{(VW-PW_BITS){1'b0}}, max_ff});
      prod_x   = $signed({{(VW-PRW){1'b0}}, prod_ff});
      if (step_ff == '0) begin
         v_raw = stop_x;
      end else if (step_ff[SW-1]) begin
         v_raw = stop_x - prod_x;
      end else begin
         v_raw = stop_x + prod_x;
      end
      v_lo    = (v_raw < min_x) ? min_x : v_raw;
      v_clamp = (v_lo > max_x) ? max_x : v_lo;
      drive   = pause_ff ? stop_ff : pulse_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff  <= RESET_STOP;
         gain_ff  <= RESET_GAIN;
         min_ff   <= RESET_MIN;
         max_ff   <= RESET_MAX;
         step_ff  <= '0;
         pulse_ff <= RESET_STOP;
         pause_ff <= 1'b0;
         lock_ff  <= 1'b0;
         frame_ff <= '0;
         upd_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_STOP_WIDTH: stop_ff <= csr_wdata;
               CSR_STEP_GAIN:  gain_ff <= csr_wdata[GAIN_BITS-1:0];
               CSR_MIN_WIDTH:  min_ff  <= csr_wdata;
               CSR_MAX_WIDTH:  max_ff  <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            step_ff  <= step_in;
            pause_ff <= pause_in;
            lock_ff  <= lock_in;
            frame_ff <= frame_ff + FRAME_BITS'(1);
            upd_ff   <= up_act || down_act;
         end
         if (cmd.clamp && upd_ff) pulse_ff <= v_clamp[PW_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         up_ff     <= up_act;
         down_ff   <= down_act;
         go_ff     <= go_act;
         hold_ff   <= hold_act;
         reject_ff <= lock_ff && cmd_nz;
         report_ff <= cmd_nz;
         blink_ff  <= (frame_ff == '0);
      end
      if (cmd.square) sq_ff <= mp1 * mp1;
      if (cmd.scale) prod_ff <= sq_ff * gain_ff;
      if (cmd.emit) begin
         rsp_ff <= {6'b0,
                    blink_ff,
                    (pulse_ff < stop_ff),
                    (pulse_ff > stop_ff),
                    (report_ff ? pulse_ff : {PW_BITS{1'b0}}),
                    report_ff,
                    reject_ff,
                    hold_ff,
                    go_ff,
                    down_ff,
                    up_ff,
                    pause_ff,
                    drive};
      end
   end

   assign rsp_tdata = rsp_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (step_ff <= LIM_POS) && (step_ff >= LIM_NEG))
      else $error("step count beyond limit");

   a_toggle_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !(go_ff && hold_ff))
      else $error("pause set and cleared in one tick");

   a_pause_follows_ack: assert property (@(posedge clock) disable iff (reset)
      cmd.load && hold_act |=> pause_ff)
      else $error("pause acknowledged but not set");

endmodule

// ===== rtl/servo_speed_command_control_top.sv =====
// Servo speed command control block: top level
//
// One req_ transaction is one control tick: three button levels and an optional
// command byte. Each tick gives exactly one rsp_ transaction with the drive
// width, acknowledge flags, a width report and LED hints.
// The csr_ port writes stop width, step gain and clamp floor/ceiling; write it
// only while no tick is in work.
// A tick accepted in the idle state passes through the square, scale and clamp
// states and is loaded into the output register from the done state; square,
// gain multiply and clamp each own a register stage. The next tick is taken
// only once the controller is back in idle, so one tick is worked on at a time.
// When the receiver stalls, the finished result waits in the output register
// and a new tick is still accepted and computed; it then waits in the last
// stage until the output register is free.
// Reset is synchronous: step count zero, stored width at the stop width,
// running, no lockout, blink frame counter zero, registers at their defaults.
module servo_speed_command_control_top
   import sscc_pkg::*;
#(
   parameter int STEP_LIMIT = 63
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // right_pressed, stop_pressed, left_pressed, command_byte[7:0]
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // drive_width[11:0], is_paused, ack_up, ack_down, ack_go, ack_pause,
   // ack_reject, report_valid, report_width[11:0], led_green, led_red, blink_frame
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                      csr_we,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [PW_BITS-1:0]        csr_wdata
);

   sscc_cmd_type cmd;

   sscc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   sscc_datapath #(
      .STEP_LIMIT (STEP_LIMIT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

endmodule

// ===== test/servo_speed_command_control_top_tb.sv =====
// self-checking testbench of the servo speed command control block
module servo_speed_command_control_top_tb;
   import sscc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STEP_LIMIT      = 63;
   localparam int PHASES          = 6;
   localparam int TICKS_PER_PHASE = 315;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int LONG_HOLD       = 300;

   typedef struct packed {
      logic [REQ_TDATA_BITS-CMD_BITS-4:0] pad;
      logic [CMD_BITS-1:0]                cmd;
      logic                               left;
      logic                               stop;
      logic                               right;
   } tick_type;

   typedef struct packed {
      logic [RSP_TDATA_BITS-2*PW_BITS-11:0] pad;
      logic                                 blink;
      logic                                 red;
      logic                                 green;
      logic [PW_BITS-1:0]                   report_width;
      logic                                 report_valid;
      logic                                 reject;
      logic                                 ack_pause;
      logic                                 ack_go;
      logic                                 ack_down;
      logic                                 ack_up;
      logic                                 paused;
      logic [PW_BITS-1:0]                   drive_width;
   } result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   tick_type                req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   result_type              rsp_tdata;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_STOP_WIDTH;
   logic [PW_BITS-1:0]      csr_wdata = '0;

   servo_speed_command_control_top #(.STEP_LIMIT(STEP_LIMIT)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // register copies and block state as predicted
   logic [PW_BITS-1:0]   cfg_stop = RESET_STOP;
   logic [GAIN_BITS-1:0] cfg_gain = RESET_GAIN;
   logic [PW_BITS-1:0]   cfg_min  = RESET_MIN;
   logic [PW_BITS-1:0]   cfg_max  = RESET_MAX;
   int                   steps = 0;
   logic [PW_BITS-1:0]   pulse = RESET_STOP;
   logic                 paused_now = 1'b0;
   logic                 locked = 1'b0;
   logic [FRAME_BITS-1:0] frame_cnt = '0;

   tick_type   tick_q[$];
   result_type tick_results_q[$];

   int errors = 0;
   int ticks_done = 0;
   int results_checked = 0;
   int rejects_seen = 0;
   int top_step = 0;
   int bottom_step = 0;
   int settings_run = 0;
   int cycles = 0;
   int hold_req = 0;

   function automatic logic [PW_BITS-1:0] shaped_width();
      int v;
      int m;
      int sq;
      v = int'(cfg_stop);
      if (steps != 0) begin
         m  = steps < 0 ? -steps : steps;
         sq = (m + 1) * (m + 1) * int'(cfg_gain);
         v  = steps < 0 ? v - sq : v + sq;
      end
      if (v < int'(cfg_min)) v = int'(cfg_min);
      if (v > int'(cfg_max)) v = int'(cfg_max);
      return v[PW_BITS-1:0];
   endfunction

   function automatic result_type run_tick(tick_type t);
      result_type r;
      logic       up_req;
      logic       down_req;
      logic       toggle_req;
      r = '0;
      up_req     = t.right || t.cmd == CMD_PLUS || t.cmd == CMD_LOWL;
      down_req   = t.left || t.cmd == CMD_MINUS || t.cmd == CMD_LOWR;
      toggle_req = t.stop || t.cmd == CMD_SPACE;
      if (!locked) begin
         if (up_req) begin
            if (t.cmd == CMD_NONE) locked = 1'b1;
            if (paused_now) steps = 0;
            if (steps < STEP_LIMIT) steps++;
            pulse = shaped_width();
            paused_now = 1'b0;
            r.ack_up = 1'b1;
         end
         if (down_req) begin
            if (t.cmd == CMD_NONE) locked = 1'b1;
            if (paused_now) steps = 0;
            if (steps > -STEP_LIMIT) steps--;
            pulse = shaped_width();
            paused_now = 1'b0;
            r.ack_down = 1'b1;
         end
         if (toggle_req) begin
            if (t.cmd == CMD_NONE) locked = 1'b1;
            if (paused_now) begin
               paused_now = 1'b0;
               r.ack_go = 1'b1;
            end else begin
               paused_now = 1'b1;
               r.ack_pause = 1'b1;
            end
         end
      end else begin
         if (!t.right && !t.stop && !t.left) locked = 1'b0;
         if (t.cmd != CMD_NONE) r.reject = 1'b1;
      end
      r.drive_width  = paused_now ? cfg_stop : pulse;
      r.paused       = paused_now;
      r.report_valid = t.cmd != CMD_NONE;
      r.report_width = t.cmd != CMD_NONE ? pulse : '0;
      r.green        = pulse > cfg_stop;
      r.red          = pulse < cfg_stop;
      r.blink        = frame_cnt == '0;
      frame_cnt      = frame_cnt + FRAME_BITS'(1);
      return r;
   endfunction

   // stimulus building
   task automatic add_tick(logic r, logic s, logic l, logic [CMD_BITS-1:0] c);
      tick_type t;
      t = '0;
      t.right = r;
      t.stop  = s;
      t.left  = l;
      t.cmd   = c;
      tick_q.push_back(t);
   endtask

   function automatic logic [CMD_BITS-1:0] step_cmd(int up_bias);
      if ($urandom_range(0, 99) < up_bias) return $urandom_range(0, 1) ? CMD_PLUS : CMD_LOWL;
      return $urandom_range(0, 1) ? CMD_MINUS : CMD_LOWR;
   endfunction

   function automatic logic [CMD_BITS-1:0] any_cmd();
      case ($urandom_range(0, 7))
         0: return CMD_PLUS;
         1: return CMD_LOWL;
         2: return CMD_MINUS;
         3: return CMD_LOWR;
         4: return CMD_SPACE;
         5: return CMD_NONE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // one gesture of an operator; returns the number of ticks it added
   task automatic add_gesture(int up_bias, output int n);
      int k;
      int len;
      int b;
      logic r, s, l;
      logic [CMD_BITS-1:0] c;
      k = $urandom_range(0, 99);
      n = 0;
      if (k < 30 || (k >= 60 && k < 70)) begin
         b = $urandom_range(0, 99);
         r = b < up_bias * 85 / 100;
         l = !r && b < 85;
         s = !r && !l;
         if ($urandom_range(0, 9) == 0) begin
            r = r | 1'($urandom_range(0, 1));
            l = l | 1'($urandom_range(0, 1));
         end
         len = $urandom_range(1, 3);
         repeat (len) begin
            c = k >= 60 ? any_cmd() : CMD_NONE;
            add_tick(r, s, l, n == 0 ? CMD_NONE : c);
            n++;
         end
         repeat ($urandom_range(1, 2)) begin
            add_tick(1'b0, 1'b0, 1'b0, k >= 60 && $urandom_range(0, 1) ? any_cmd() : CMD_NONE);
            n++;
         end
      end else if (k < 48) begin
         c = step_cmd(up_bias);
         len = $urandom_range(1, 40);
         repeat (len) add_tick(1'b0, 1'b0, 1'b0, c);
         n = len;
      end else if (k < 52) begin
         c = step_cmd(up_bias);
         len = $urandom_range(64, 130);
         repeat (len) add_tick(1'b0, 1'b0, 1'b0, c);
         n = len;
      end else if (k < 60) begin
         add_tick(1'b0, 1'b0, 1'b0, $urandom_range(0, 1) ? CMD_SPACE : CMD_NONE);
         n = 1;
      end else if (k < 78) begin
         add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
         n = 1;
      end else begin
         b = $urandom_range(0, 3);
         c = b < 2 ? CMD_NONE : (b == 2 ? any_cmd() : 8'($urandom_range(0, 255)));
         add_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), c);
         n = 1;
      end
   endtask

   task automatic write_reg(logic [CSR_IDX_BITS-1:0] idx, logic [PW_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_STOP_WIDTH: cfg_stop = val;
         CSR_STEP_GAIN:  cfg_gain = val[GAIN_BITS-1:0];
         CSR_MIN_WIDTH:  cfg_min  = val;
         CSR_MAX_WIDTH:  cfg_max  = val;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_regs(int stop_w, int gain, int min_w, int max_w);
      write_reg(CSR_STOP_WIDTH, PW_BITS'(stop_w));
      write_reg(CSR_STEP_GAIN, PW_BITS'(gain));
      write_reg(CSR_MIN_WIDTH, PW_BITS'(min_w));
      write_reg(CSR_MAX_WIDTH, PW_BITS'(max_w));
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (tick_q.size() > 0 || req_tvalid || tick_results_q.size() > 0);
      repeat (8) @(posedge clock);
   endtask

   // driver: bursts of transactions with random gaps
   logic     drv_valid;
   tick_type drv_data;
   int       burst_left = 1;
   int       gap_left = 0;

   always @(posedge clock) begin
      drv_valid = req_tvalid;
      drv_data  = req_tdata;
      if (reset) begin
         drv_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            tick_results_q.push_back(run_tick(req_tdata));
            ticks_done++;
            if (steps > top_step) top_step = steps;
            if (steps < bottom_step) bottom_step = steps;
            drv_valid = 1'b0;
         end
         if (!drv_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (tick_q.size() > 0) begin
               drv_data  = tick_q.pop_front();
               drv_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
      req_tvalid <= drv_valid;
      req_tdata  <= drv_data;
   end

   // receiver stall pattern, with a long hold-off on request
   int hold_cnt = 0;
   int hold_seen = 0;
   int stall_mode = 0;
   int mode_left = 0;

   always @(posedge clock) begin
      if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (hold_seen != hold_req) begin
         hold_seen <= hold_req;
         hold_cnt <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            mode_left <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            2: rsp_tready <= $urandom_range(0, 3) != 0;
            default: rsp_tready <= $urandom_range(0, 3) == 0;
         endcase
      end
   end

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t %s: expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // monitor: compare every result transaction with the oldest prediction
   result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tick_results_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none actual %h", $time, rsp_tdata);
         end else begin
            want = tick_results_q.pop_front();
            results_checked++;
            if (want.reject) rejects_seen++;
            check_field("drive_width", int'(want.drive_width), int'(rsp_tdata.drive_width));
            check_field("is_paused", int'(want.paused), int'(rsp_tdata.paused));
            check_field("ack_up", int'(want.ack_up), int'(rsp_tdata.ack_up));
            check_field("ack_down", int'(want.ack_down), int'(rsp_tdata.ack_down));
            check_field("ack_go", int'(want.ack_go), int'(rsp_tdata.ack_go));
            check_field("ack_pause", int'(want.ack_pause), int'(rsp_tdata.ack_pause));
            check_field("ack_reject", int'(want.reject), int'(rsp_tdata.reject));
            check_field("report_valid", int'(want.report_valid),
                        int'(rsp_tdata.report_valid));
            check_field("report_width", int'(want.report_width),
                        int'(rsp_tdata.report_width));
            check_field("led_green", int'(want.green), int'(rsp_tdata.green));
            check_field("led_red", int'(want.red), int'(rsp_tdata.red));
            check_field("blink_frame", int'(want.blink), int'(rsp_tdata.blink));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, tick_results_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int n;
      int queued;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: ;
            1: set_regs(500, 1, 0, 4095);
            2: set_regs(2400, 15, 500, 2400);
            3: set_regs(1500, 7, 3000, 1000);
            4: set_regs($urandom_range(500, 2400), $urandom_range(1, 15),
                        $urandom_range(0, 1500), $urandom_range(1500, 4095));
            default: set_regs(500, 1, 4095, 4095);
         endcase
         settings_run++;
         @(negedge clock);
         queued = 0;
         if (ph == 0) begin
            // every command, toggle both ways, unknown bytes, lockout and release
            add_tick(1'b0, 1'b0, 1'b0, CMD_PLUS);
            add_tick(1'b0, 1'b0, 1'b0, CMD_LOWL);
            add_tick(1'b0, 1'b0, 1'b0, CMD_MINUS);
            add_tick(1'b0, 1'b0, 1'b0, CMD_LOWR);
            add_tick(1'b0, 1'b0, 1'b0, CMD_MINUS);
            add_tick(1'b0, 1'b0, 1'b0, CMD_SPACE);
            add_tick(1'b0, 1'b0, 1'b0, CMD_SPACE);
            add_tick(1'b0, 1'b0, 1'b0, CMD_SPACE);
            add_tick(1'b0, 1'b0, 1'b0, CMD_PLUS);
            add_tick(1'b0, 1'b0, 1'b0, CMD_NONE);
            add_tick(1'b0, 1'b0, 1'b0, 8'h78);
            add_tick(1'b0, 1'b0, 1'b0, 8'hFF);
            add_tick(1'b1, 1'b0, 1'b0, CMD_NONE);
            add_tick(1'b1, 1'b0, 1'b0, CMD_PLUS);
            add_tick(1'b1, 1'b1, 1'b0, CMD_NONE);
            add_tick(1'b0, 1'b0, 1'b0, CMD_NONE);
            add_tick(1'b0, 1'b0, 1'b1, CMD_NONE);
            add_tick(1'b0, 1'b0, 1'b0, CMD_NONE);
            add_tick(1'b0, 1'b1, 1'b0, CMD_NONE);
            add_tick(1'b0, 1'b0, 1'b0, CMD_NONE);
            add_tick(1'b0, 1'b1, 1'b0, CMD_NONE);
            add_tick(1'b0, 1'b0, 1'b0, CMD_NONE);
            add_tick(1'b1, 1'b1, 1'b1, CMD_NONE);
            add_tick(1'b0, 1'b0, 1'b0, CMD_NONE);
            add_tick(1'b1, 1'b0, 1'b0, CMD_SPACE);
            queued = 25;
         end
         if (ph == 1 || ph == 2) begin
            repeat (70) add_tick(1'b0, 1'b0, 1'b0, CMD_PLUS);
            repeat (140) add_tick(1'b0, 1'b0, 1'b0, CMD_LOWR);
            queued += 210;
         end
         // receiver holds off while the sender keeps offering
         if (ph == 2) hold_req++;
         while (queued < TICKS_PER_PHASE) begin
            add_gesture(ph == 3 ? 20 : (ph % 2 ? 50 : 75), n);
            queued += n;
         end
         wait_drained();
      end
      repeat (10) @(posedge clock);
      $display("%0d ticks over %0d register settings, %0d results checked, %0d rejects",
               ticks_done, settings_run, results_checked, rejects_seen);
      $display("step count ranged from %0d to %0d", bottom_step, top_step);
      if (errors == 0 && tick_results_q.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
